// ----- hdl/fpsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpsa_pkg
// Shared types, codes and constants of the free page stack allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

  // Fixed field widths
  localparam int ADDR_W = 32;
  localparam int IDLE_W = 11;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int OUT_TDATA_W = 112;

  // Defaults for the top level parameters
  localparam int MAX_PAGES_DEF  = 1024;
  localparam int PAGE_SHIFT_DEF = 12;

  // Register reset values
  localparam logic [ADDR_W-1:0] REGION_LOW_RST = 32'h8022_0000;
  localparam logic [ADDR_W-1:0] REGION_TOP_RST = 32'h8060_0000;

  // Register indexes
  localparam logic CFG_REGION_LOW = 1'b0;
  localparam logic CFG_REGION_TOP = 1'b1;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_ADDR = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

  // One finished result word
  typedef struct packed {
    logic [ADDR_W-1:0] alloc_addr;
    logic [STAT_W-1:0] status;
    logic [IDLE_W-1:0] idle_pages;
    logic [ADDR_W-1:0] alloc_total;
    logic [ADDR_W-1:0] free_total;
  } fpsa_res_t;

endpackage

// ----- hdl/fpsa_stack_ram.sv -----
// ----------------------------------------------------------------------------
// fpsa_stack_ram
// Single write port, single read port page number memory, registered read.
// ----------------------------------------------------------------------------
module fpsa_stack_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 20
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_idx,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_idx,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read the stack entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_idx];
  end

endmodule

// ----- hdl/fpsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpsa_ctrl
// Operation sequencer: push, pop and init walk over the page stack memory,
// plus the idle count and both totals.
// ----------------------------------------------------------------------------
module fpsa_ctrl
  import fpsa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [ADDR_W-1:0] region_low,
  input  logic [ADDR_W-1:0] region_top,
  output logic              res_valid,
  input  logic              res_ready,
  output fpsa_res_t         res
);

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam int PN_W  = ADDR_W - PAGE_SHIFT;
  localparam logic [ADDR_W:0] PG_BYTES = {{ADDR_W{1'b0}}, 1'b1} << PAGE_SHIFT;
  localparam logic [ADDR_W:0] PG_MASK  = PG_BYTES - {{ADDR_W{1'b0}}, 1'b1};
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAGES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [ADDR_W-1:0] TOT_ONE = ADDR_W'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_INIT = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] alloc_r, alloc_nxt;
  logic [ADDR_W-1:0] free_r, free_nxt;
  logic [ADDR_W:0]   walk_r, walk_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_wr_idx;
  logic [PN_W-1:0]   ram_wr_data;
  logic [IDX_W-1:0]  ram_rd_idx;
  logic [PN_W-1:0]   ram_rd_data;

  logic [CNT_W-1:0]        cnt_dec;
  logic [ADDR_W:0]         low_up;
  logic [ADDR_W:0]         walk_start;
  logic [ADDR_W:0]         walk_end;
  logic                    walk_fits;
  logic                    pool_full;
  logic                    addr_bad;
  logic [CNT_W+IDLE_W-1:0] count_ext;

  // Derive the stack pointers and range checks
  assign cnt_dec     = count_r - CNT_ONE;
  assign ram_rd_idx  = cnt_dec[IDX_W-1:0];
  assign ram_wr_idx  = count_r[IDX_W-1:0];
  assign pool_full   = (count_r >= CNT_MAX);
  assign low_up      = {1'b0, region_low} + PG_MASK;
  assign walk_start  = low_up & ~PG_MASK;
  assign walk_end    = walk_r + PG_BYTES;
  assign walk_fits   = (walk_end <= {1'b0, region_top});
  assign addr_bad    = (in_addr[PAGE_SHIFT-1:0] != '0) || (in_addr < region_low) ||
                       (in_addr >= region_top);

  fpsa_stack_ram #(
    .DEPTH (MAX_PAGES),
    .WIDTH (PN_W)
  ) u_stack_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_idx    (ram_wr_idx),
    .wr_data   (ram_wr_data),
    .rd_idx    (ram_rd_idx),
    .rd_data_r (ram_rd_data)
  );

  // Sequence one operation
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    alloc_nxt      = alloc_r;
    free_nxt       = free_r;
    walk_nxt       = walk_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_wr_data    = in_addr[ADDR_W-1:PAGE_SHIFT];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_addr_nxt   = '0;
          res_status_nxt = STAT_OK;
          state_nxt      = S_EMIT;
          case (in_func)
            FUNC_INIT: begin
              count_nxt = '0;
              alloc_nxt = '0;
              free_nxt  = '0;
              walk_nxt  = walk_start;
              state_nxt = S_INIT;
            end
            FUNC_ALLOC: begin
              alloc_nxt = alloc_r + TOT_ONE;
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                count_nxt = cnt_dec;
                state_nxt = S_POP;
              end
            end
            FUNC_FREE: begin
              if (addr_bad) begin
                res_status_nxt = STAT_BAD_ADDR;
              end else if (pool_full) begin
                res_status_nxt = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_ONE;
                free_nxt  = free_r + TOT_ONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        res_addr_nxt = {ram_rd_data, {PAGE_SHIFT{1'b0}}};
        state_nxt    = S_EMIT;
      end
      S_INIT: begin
        ram_wr_data = walk_r[ADDR_W-1:PAGE_SHIFT];
        if (!walk_fits) begin
          state_nxt = S_EMIT;
        end else if (pool_full) begin
          res_status_nxt = STAT_FULL;
          state_nxt      = S_EMIT;
        end else begin
          ram_we    = 1'b1;
          count_nxt = count_r + CNT_ONE;
          free_nxt  = free_r + TOT_ONE;
          walk_nxt  = walk_end;
        end
      end
      S_EMIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      alloc_r <= '0;
      free_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      alloc_r <= alloc_nxt;
      free_r  <= free_nxt;
    end
  end

  // Hold the walk pointer and the result fields
  always_ff @(posedge clk) begin
    walk_r       <= walk_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

  // Present the finished word
  assign count_ext       = {{IDLE_W{1'b0}}, count_r};
  assign in_ready        = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_EMIT);
  assign res.alloc_addr  = res_addr_r;
  assign res.status      = res_status_r;
  assign res.idle_pages  = count_ext[IDLE_W-1:0];
  assign res.alloc_total = alloc_r;
  assign res.free_total  = free_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("page count beyond pool depth");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (count_r < CNT_MAX))
    else $error("stack write with pool full");

  a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_func == FUNC_ALLOC && count_r != '0) |=>
      (state_r == S_POP && count_r == $past(cnt_dec)))
    else $error("pop did not decrement the stack");

  a_bad_free_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_func == FUNC_FREE && addr_bad) |=>
      ($stable(count_r) && res_status_r == STAT_BAD_ADDR))
    else $error("bad free changed the pool");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_status_r) &&
      $stable(res_addr_r) && $stable(count_r)))
    else $error("stalled result changed");

endmodule

// ----- hdl/free_page_stack_allocator_top.sv -----
// ----------------------------------------------------------------------------
// free_page_stack_allocator_top
// LIFO pool of physical pages with init, alloc and free operations.
// ----------------------------------------------------------------------------
// One word goes in, one result word comes out. A free, or an unused function
// code, goes from the idle to the emit state; an alloc passes through a pop
// state in between, since the popped page number comes from the stack memory
// in the cycle after its read address is set. An init walks the managed range
// with one memory write per cycle until the range ends or the pool is full.
// The block takes one word at a time; the next word is accepted once the
// previous result has moved into the output register, so one finished result
// may wait there while the next operation runs. Region registers must be
// written only while the block is idle; the block itself does not enforce
// this. Stack entries hold no defined value after reset; only entries already
// pushed are ever popped.
// ----------------------------------------------------------------------------
module free_page_stack_allocator_top
  import fpsa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port
  input  logic                   cfg_wr_en,
  input  logic                   cfg_idx,
  input  logic [ADDR_W-1:0]      cfg_wdata,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [ADDR_W-1:0]      in_tdata,  // [31:0] page_addr
  input  logic [FUNC_W-1:0]      in_tuser,  // [1:0] func
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // [31:0] alloc_addr, [42:32] idle_pages,
                                            // [74:43] alloc_total, [106:75] free_total,
                                            // [111:107] zero
  output logic [STAT_W-1:0]      out_tuser  // [1:0] status
);

  localparam int PAD_W = OUT_TDATA_W - (3 * ADDR_W + IDLE_W);

  logic [ADDR_W-1:0] region_low_r;
  logic [ADDR_W-1:0] region_top_r;
  logic              res_valid;
  logic              res_ready;
  fpsa_res_t         res;
  logic              out_valid_r, out_valid_nxt;
  fpsa_res_t         out_res_r;

  // Write region registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_low_r <= REGION_LOW_RST;
      region_top_r <= REGION_TOP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        CFG_REGION_LOW: region_low_r <= cfg_wdata;
        CFG_REGION_TOP: region_top_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  fpsa_ctrl #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_func    (in_tuser),
    .in_addr    (in_tdata),
    .region_low (region_low_r),
    .region_top (region_top_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Advance the output register when it is empty or drains
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  // Pack the result word
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {{PAD_W{1'b0}}, out_res_r.free_total, out_res_r.alloc_total,
                       out_res_r.idle_pages, out_res_r.alloc_addr};

endmodule

// ----- bench/free_page_stack_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// free_page_stack_allocator_top_tb
// Self-checking bench for the free page stack allocator.
// ----------------------------------------------------------------------------
// A ledger class keeps its own page stack, pool depth, both totals and the
// region bounds. It predicts the result of every accepted operation word and
// checks each result word, field by field, in order. A short directed run
// covers the corner cases: empty pool, the unused function code, bad free
// addresses, page zero, an empty range, init overflow and a free onto a full
// pool. Random phases follow, each with new region bounds and an init, then
// mostly allocs and frees of in-range pages mixed with bad frees and noise.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module free_page_stack_allocator_top_tb
  import fpsa_pkg::*;
;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam longint unsigned PAGE_BYTES = 64'd1 << PAGE_SHIFT_DEF;
  localparam int STALL_LIMIT = 8000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_WORDS = 80;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic                   cfg_idx;
  logic [ADDR_W-1:0]      cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [ADDR_W-1:0]      in_tdata;
  logic [FUNC_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;

  logic [15:0]            rx_tick = '0;
  int                     quiet_cycles = 0;

  // Page pool ledger: mirrors the pool and queues the expected result words
  class page_pool_ledger;
    logic [ADDR_W-PAGE_SHIFT_DEF-1:0] page_num [MAX_PAGES_DEF];
    int unsigned       depth;
    logic [ADDR_W-1:0] alloc_cnt;
    logic [ADDR_W-1:0] free_cnt;
    logic [ADDR_W-1:0] region_low;
    logic [ADDR_W-1:0] region_top;
    fpsa_res_t         pending[$];
    int                mismatches;

    function new();
      depth      = 0;
      alloc_cnt  = '0;
      free_cnt   = '0;
      region_low = REGION_LOW_RST;
      region_top = REGION_TOP_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [ADDR_W-1:0] val);
      if (idx == CFG_REGION_LOW) begin
        region_low = val;
      end else begin
        region_top = val;
      end
    endfunction

    // Push one page; fail when the pool is full
    function bit push_page(longint unsigned addr);
      if (depth >= MAX_PAGES_DEF) return 1'b0;
      page_num[depth] = addr >> PAGE_SHIFT_DEF;
      depth++;
      free_cnt++;
      return 1'b1;
    endfunction

    // Apply one accepted operation word and queue its result
    function void note_word(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] addr);
      fpsa_res_t       r;
      longint unsigned p;
      r.alloc_addr = '0;
      r.status     = STAT_OK;
      case (func)
        FUNC_INIT: begin
          p = {32'b0, region_low};
          p = (p + PAGE_BYTES - 1) & ~(PAGE_BYTES - 1);
          depth     = 0;
          alloc_cnt = '0;
          free_cnt  = '0;
          while (p + PAGE_BYTES <= {32'b0, region_top}) begin
            if (!push_page(p)) begin
              r.status = STAT_FULL;
              break;
            end
            p += PAGE_BYTES;
          end
        end
        FUNC_ALLOC: begin
          alloc_cnt++;
          if (depth == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            depth--;
            r.alloc_addr = {page_num[depth], {PAGE_SHIFT_DEF{1'b0}}};
          end
        end
        FUNC_FREE: begin
          if (addr[PAGE_SHIFT_DEF-1:0] != '0 || addr < region_low || addr >= region_top) begin
            r.status = STAT_BAD_ADDR;
          end else if (!push_page({32'b0, addr})) begin
            r.status = STAT_FULL;
          end
        end
        default: ;
      endcase
      r.idle_pages  = IDLE_W'(depth);
      r.alloc_total = alloc_cnt;
      r.free_total  = free_cnt;
      pending.push_back(r);
    endfunction

    task report(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
      mismatches++;
    endtask

    // Compare one result word with the oldest expectation
    task check_word(logic [OUT_TDATA_W-1:0] data, logic [STAT_W-1:0] stat);
      fpsa_res_t w;
      if (pending.size() == 0) begin
        report("unexpected result word", data[31:0], '0);
        return;
      end
      w = pending.pop_front();
      if (data[31:0] !== w.alloc_addr) report("alloc_addr", data[31:0], w.alloc_addr);
      if (stat !== w.status) report("status", stat, w.status);
      if (data[42:32] !== w.idle_pages) report("idle_pages", data[42:32], w.idle_pages);
      if (data[74:43] !== w.alloc_total) report("alloc_total", data[74:43], w.alloc_total);
      if (data[106:75] !== w.free_total) report("free_total", data[106:75], w.free_total);
    endtask
  endclass

  page_pool_ledger pool = new();

  free_page_stack_allocator_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] page_addr
    .in_tuser   (in_tuser),   // [1:0] func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] alloc_addr, [42:32] idle_pages,
                              // [74:43] alloc_total, [106:75] free_total
    .out_tuser  (out_tuser)   // [1:0] status
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the receiver: always ready, coin flip, mostly stalled, periodic
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    case (rx_tick[8:7])
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= 1'($urandom_range(0, 1));
      2'd2:    out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (rx_tick[2:0] < 3'd5);
    endcase
  end

  // Sample handshakes, track register writes, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) pool.check_word(out_tdata, out_tuser);
      if (in_tvalid && in_tready) pool.note_word(in_tuser, in_tdata);
      if (cfg_wr_en) pool.write_reg(cfg_idx, cfg_wdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) || cfg_wr_en) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one operation word and hold it until taken
  task put_word(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] addr);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid for a gap of the given length
  task hold_off(int unsigned cycles);
    if (cycles == 0) return;
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stop sending until every expected result word is back
  task drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pool.pending.size() != 0) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task set_region(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] top);
    write_reg(CFG_REGION_LOW, lo);
    write_reg(CFG_REGION_TOP, top);
  endtask

  // Aligned page inside the current region, or noise when there is none
  function logic [ADDR_W-1:0] good_page();
    longint unsigned base;
    longint unsigned n;
    base = ({32'b0, pool.region_low} + PAGE_BYTES - 1) & ~(PAGE_BYTES - 1);
    n = (pool.region_top > base) ? (pool.region_top - base) / PAGE_BYTES : 0;
    if (n == 0) return $urandom;
    return ADDR_W'(base + PAGE_BYTES * $urandom_range(32'(n - 1), 0));
  endfunction

  // Unaligned, below the region, at or past its top, or plain noise
  function logic [ADDR_W-1:0] bad_page();
    case ($urandom_range(0, 3))
      0: return good_page() | ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
      1: return ((pool.region_low - 32'd1) >> PAGE_SHIFT_DEF) << PAGE_SHIFT_DEF;
      2: return ((pool.region_top + 32'hFFF) >> PAGE_SHIFT_DEF) << PAGE_SHIFT_DEF;
      default: return $urandom;
    endcase
  endfunction

  // New random bounds: small aligned range, unaligned range, low range, high end
  task pick_region();
    longint unsigned lo;
    longint unsigned top;
    case ($urandom_range(0, 3))
      0: begin
        lo  = $urandom & 32'hFFFF_F000;
        top = lo + PAGE_BYTES * $urandom_range(1, 40);
      end
      1: begin
        lo  = $urandom;
        top = lo + $urandom_range(0, 64 * PAGE_BYTES);
      end
      2: begin
        lo  = 0;
        top = PAGE_BYTES * $urandom_range(1, 24) + $urandom_range(0, PAGE_BYTES - 1);
      end
      default: begin
        lo  = 64'hFFFE_0000 + $urandom_range(0, PAGE_BYTES);
        top = 64'hFFFF_FFFF;
      end
    endcase
    if (top > 64'hFFFF_FFFF) top = 64'hFFFF_FFFF;
    set_region(lo[31:0], top[31:0]);
  endtask

  initial begin
    int unsigned burst;
    int unsigned pick;
    bit          gapless;

    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_idx    = CFG_REGION_LOW;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = FUNC_INIT;
    out_tready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset bounds: empty pool, unused code, bad frees, a good free and alloc, then a full-range init
    put_word(FUNC_ALLOC, 32'hFFFF_FFFF);
    put_word(FUNC_NONE, 32'hFFFF_FFFF);
    put_word(FUNC_FREE, 32'h8022_0001);
    put_word(FUNC_FREE, 32'h8021_F000);
    put_word(FUNC_FREE, 32'h8060_0000);
    put_word(FUNC_FREE, 32'h8022_0000);
    put_word(FUNC_ALLOC, 32'h0);
    put_word(FUNC_INIT, 32'h0);
    put_word(FUNC_ALLOC, 32'h0);
    put_word(FUNC_FREE, 32'h805F_F000);

    // Low range: page zero comes back, then the pool runs dry
    drain_results();
    set_region(32'h0, 32'h3000);
    put_word(FUNC_INIT, 32'h0);
    repeat (4) put_word(FUNC_ALLOC, 32'h0);

    // Empty range at the very top
    drain_results();
    set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_word(FUNC_INIT, 32'h0);
    put_word(FUNC_FREE, 32'hFFFF_F000);

    // Whole address space: init overflows, free onto a full pool
    drain_results();
    set_region(32'h0, 32'hFFFF_FFFF);
    put_word(FUNC_INIT, 32'h0);
    put_word(FUNC_FREE, 32'h0000_5000);
    put_word(FUNC_ALLOC, 32'h0);
    put_word(FUNC_FREE, 32'h003F_F000);
    put_word(FUNC_NONE, 32'h0);

    // Random phases: new bounds, init, then mostly well-formed traffic
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      pick_region();
      put_word(FUNC_INIT, $urandom);
      burst   = 0;
      gapless = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 20);
          if (!gapless) hold_off($urandom_range(1, 8));
        end
        burst--;
        if ($urandom_range(0, 59) == 0) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          put_word(FUNC_ALLOC, $urandom);
        end else if (pick < 80) begin
          put_word(FUNC_FREE, good_page());
        end else if (pick < 93) begin
          put_word(FUNC_FREE, bad_page());
        end else if (pick < 97) begin
          put_word(FUNC_NONE, $urandom);
        end else begin
          put_word(FUNC_INIT, $urandom);
        end
      end
    end

    // Let the last words out and watch for strays
    drain_results();
    repeat (8) @(posedge clk);
    if (pool.mismatches == 0 && pool.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
